@@ rtl/bes_pkg.sv @@
// Package: shared constants, codes and types of the bus error system registers.
package bes_pkg;

  localparam int WCS_ADDR_BITS = 13;

  localparam logic [15:0] WCSA_ADDR_MASK = 16'((32'd1 << WCS_ADDR_BITS) - 32'd1);
  localparam logic [15:0] WCSA_CTR_MASK  = 16'h6000;
  localparam logic [15:0] WCSA_CTR_STEP  = 16'h2000;
  localparam logic [31:0] WCSD_READ_VAL  = 32'h0000_00FF;
  localparam logic [12:0] MBRK_MASK      = 13'h1FFF;
  localparam logic [31:0] FS_WMASK       = 32'h0314_0000;
  localparam logic [31:0] FS_W1C         = 32'h0008_0000;
  localparam logic [31:0] SC_RMASK       = 32'hFFFF_0000;
  localparam logic [31:0] SC_WMASK       = 32'h7FFF_0000;
  localparam logic [31:0] MT_RMASK       = 32'hFFFF_FF00;
  localparam logic [31:0] MT_WMASK       = 32'hFFFF_F900;
  localparam logic [15:0] ER_CRDIE       = 16'h8000;
  localparam logic [15:0] ER_CRD         = 16'h4000;
  localparam logic [15:0] ER_TMO         = 16'h1000;
  localparam logic [15:0] ER_STA         = 16'h0C00;
  localparam logic [15:0] ER_CNF         = 16'h0100;
  localparam logic [15:0] ER_IBTMO       = 16'h0040;
  localparam logic [15:0] ER_IBCNF       = 16'h0008;
  localparam logic [15:0] ER_MULT        = 16'h0004;
  localparam logic [15:0] ER_RMASK       = 16'hFDFE;
  localparam logic [15:0] ER_WMASK       = 16'h8000;
  localparam logic [15:0] ER_W1C         = 16'h70C0;
  localparam logic [15:0] ER_TMO_CLR     = ER_TMO | ER_STA | ER_CNF | ER_MULT;
  localparam logic [15:0] ER_IBT_CLR     = ER_IBTMO | ER_STA | ER_IBCNF;

  typedef enum logic [2:0] {
    MODE_READ    = 3'd0,
    MODE_WRITE   = 3'd1,
    MODE_TIMEOUT = 3'd2,
    MODE_CONFIRM = 3'd3,
    MODE_MCHK    = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    SEL_WCSA  = 4'd0,
    SEL_WCSD  = 4'd1,
    SEL_FAULT = 4'd2,
    SEL_SILO  = 4'd3,
    SEL_MAINT = 4'd4,
    SEL_ERROR = 4'd5,
    SEL_TMO   = 4'd6,
    SEL_MBRK  = 4'd7,
    SEL_SBIS  = 4'd8,
    SEL_ACCS  = 4'd9
  } sel_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  reg_select;
    logic [31:0] write_data;
    logic [29:0] bus_address;
    logic        access_is_read;
    logic        virtual_ref;
    logic [1:0]  current_mode;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        status;
    logic        mcheck;
    logic        memory_error;
    logic        crd_interrupt;
    logic [31:0] captured_timeout;
  } rsp_t;

endpackage

@@ rtl/bes_req_if.sv @@
// Interface: request channel carrying register accesses and bus events.
interface bes_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [3:0]  reg_select;
  logic [31:0] write_data;
  logic [29:0] bus_address;
  logic        access_is_read;
  logic        virtual_ref;
  logic [1:0]  current_mode;

  modport source (output valid, mode, reg_select, write_data, bus_address,
                  access_is_read, virtual_ref, current_mode, input ready);
  modport sink (input valid, mode, reg_select, write_data, bus_address,
                access_is_read, virtual_ref, current_mode, output ready);
endinterface

@@ rtl/bes_rsp_if.sv @@
// Interface: response channel carrying one result per request.
interface bes_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        status;
  logic        mcheck;
  logic        memory_error;
  logic        crd_interrupt;
  logic [31:0] captured_timeout;

  modport source (output valid, read_data, status, mcheck, memory_error,
                  crd_interrupt, captured_timeout, input ready);
  modport sink (input valid, read_data, status, mcheck, memory_error,
                crd_interrupt, captured_timeout, output ready);
endinterface

@@ rtl/bes_regs.sv @@
// Register file: system register state and its per-transfer update and result.
module bes_regs
  import bes_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  req_t req,
  output rsp_t rsp
);

  logic [15:0] wcs_address, wcs_address_next;
  logic [31:0] wcs_word, wcs_word_next;
  logic [12:0] micro_break, micro_break_next;
  logic [31:0] fault_status, fault_status_next;
  logic [31:0] silo_compare, silo_compare_next;
  logic [31:0] maintenance, maintenance_next;
  logic [15:0] error_status, error_status_next;
  logic [31:0] timeout_address, timeout_address_next;
  logic        crd_pending, crd_pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      wcs_address     <= '0;
      wcs_word        <= '0;
      micro_break     <= '0;
      fault_status    <= '0;
      silo_compare    <= '0;
      maintenance     <= '0;
      error_status    <= '0;
      timeout_address <= '0;
      crd_pending     <= 1'b0;
    end else if (en) begin
      wcs_address     <= wcs_address_next;
      wcs_word        <= wcs_word_next;
      micro_break     <= micro_break_next;
      fault_status    <= fault_status_next;
      silo_compare    <= silo_compare_next;
      maintenance     <= maintenance_next;
      error_status    <= error_status_next;
      timeout_address <= timeout_address_next;
      crd_pending     <= crd_pending_next;
    end
  end

  always_comb begin
    logic [15:0] wa;
    logic [15:0] es;
    logic [31:0] wd;
    wd                   = req.write_data;
    wa                   = '0;
    es                   = '0;
    wcs_address_next     = wcs_address;
    wcs_word_next        = wcs_word;
    micro_break_next     = micro_break;
    fault_status_next    = fault_status;
    silo_compare_next    = silo_compare;
    maintenance_next     = maintenance;
    error_status_next    = error_status;
    timeout_address_next = timeout_address;
    crd_pending_next     = crd_pending;
    rsp                  = '0;

    unique case (mode_t'(req.mode))
      MODE_READ: begin
        unique case (sel_t'(req.reg_select))
          SEL_WCSA:  rsp.read_data = {16'h0000, wcs_address};
          SEL_WCSD:  rsp.read_data = WCSD_READ_VAL;
          SEL_FAULT: rsp.read_data = fault_status;
          SEL_SILO:  rsp.read_data = silo_compare & SC_RMASK;
          SEL_MAINT: rsp.read_data = maintenance & MT_RMASK;
          SEL_ERROR: rsp.read_data = {16'h0000, error_status & ER_RMASK};
          SEL_TMO:   rsp.read_data = timeout_address;
          SEL_MBRK:  rsp.read_data = {19'h0, micro_break};
          SEL_SBIS, SEL_ACCS: rsp.read_data = '0;
          default:   rsp.status = 1'b1;
        endcase
      end
      MODE_WRITE: begin
        unique case (sel_t'(req.reg_select))
          SEL_WCSA: wcs_address_next = wd[15:0];
          SEL_WCSD: begin
            // Step the sub-counter; on reaching three, step the address.
            wcs_word_next = wd;
            wa = (wcs_address & ~WCSA_CTR_MASK) |
                 ((wcs_address + WCSA_CTR_STEP) & WCSA_CTR_MASK);
            if ((wa & WCSA_CTR_MASK) == WCSA_CTR_MASK) begin
              wa = (wa & ~WCSA_ADDR_MASK) | ((wa + 16'd1) & WCSA_ADDR_MASK);
            end
            wcs_address_next = wa;
          end
          SEL_FAULT: begin
            fault_status_next = ((fault_status & ~FS_WMASK) | (wd & FS_WMASK))
                                & ~(wd & FS_W1C);
          end
          SEL_SILO:  silo_compare_next = (silo_compare & ~SC_RMASK) | (wd & SC_WMASK);
          SEL_MAINT: maintenance_next = (maintenance & ~MT_WMASK) | (wd & MT_WMASK);
          SEL_ERROR: begin
            es = (error_status & ~ER_WMASK) | (wd[15:0] & ER_WMASK);
            es = es & ~(wd[15:0] & ER_W1C);
            if ((wd[15:0] & ER_TMO) != 16'h0) es = es & ~ER_TMO_CLR;
            if ((wd[15:0] & ER_IBTMO) != 16'h0) es = es & ~ER_IBT_CLR;
            error_status_next = es;
            crd_pending_next  = ((es & ER_CRDIE) != 16'h0) && ((es & ER_CRD) != 16'h0);
          end
          SEL_MBRK: micro_break_next = wd[12:0] & MBRK_MASK;
          SEL_ACCS: ;
          default:  rsp.status = 1'b1;
        endcase
      end
      MODE_TIMEOUT: begin
        // Latch the first failing address; flag any later one as multiple.
        if ((error_status & ER_TMO) == 16'h0) begin
          timeout_address_next = {req.virtual_ref ? req.current_mode : 2'b00,
                                  req.virtual_ref, 1'b0, req.bus_address[29:2]};
          error_status_next    = error_status | ER_TMO;
        end else begin
          error_status_next = error_status | ER_MULT;
        end
        rsp.mcheck       = req.access_is_read;
        rsp.memory_error = !req.access_is_read;
      end
      MODE_CONFIRM: begin
        if ((error_status & ER_CNF) != 16'h0) begin
          error_status_next = error_status | ER_MULT;
        end else begin
          error_status_next = error_status | ER_CNF;
        end
        rsp.mcheck = 1'b1;
      end
      MODE_MCHK: begin
        rsp.read_data        = {16'h0000, error_status};
        rsp.captured_timeout = timeout_address;
        error_status_next    = error_status & ~ER_TMO_CLR;
      end
      default: ;
    endcase

    rsp.crd_interrupt = crd_pending_next;
  end

endmodule

@@ rtl/bus_error_system_registers_top.sv @@
// Top level: bus error system registers with request and response channels.
//
//   Channel | Direction | Carries
//   --------+-----------+--------------------------------------------------
//   req     | in        | register read/write, bus timeout, confirm, mchk
//   rsp     | out       | read data, operand fault, mchk/memerr, CRD level
//
// One transfer on req yields exactly one transfer on rsp, sent from the response register.
// The register update and the result are worked out in the cycle of the
// request transfer; the result is held in the response register.
// A new request is taken every cycle as long as the response register is
// empty or being drained in the same cycle; a stalled rsp holds req off.
// rst (synchronous) clears all system registers and empties the response.
module bus_error_system_registers_top
  import bes_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  bes_req_if.sink   req,
  bes_rsp_if.source rsp
);

  req_t item;
  rsp_t result;
  rsp_t held;       // response register payload
  logic held_valid; // response register occupied
  logic take;

  // Accept when the response slot is free or empties this cycle.
  assign req.ready = !held_valid || rsp.ready;
  assign take      = req.valid && req.ready;

  // Gather the request fields into one item.
  assign item = '{mode:           req.mode,
                  reg_select:     req.reg_select,
                  write_data:     req.write_data,
                  bus_address:    req.bus_address,
                  access_is_read: req.access_is_read,
                  virtual_ref:    req.virtual_ref,
                  current_mode:   req.current_mode};

  // State update happens only on a request transfer.
  bes_regs u_regs (
    .clk (clk),
    .rst (rst),
    .en  (take),
    .req (item),
    .rsp (result)
  );

  // Response register: load on transfer in, drop on transfer out.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (rsp.ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= result;
    end
  end

  assign rsp.valid            = held_valid;
  assign rsp.read_data        = held.read_data;
  assign rsp.status           = held.status;
  assign rsp.mcheck           = held.mcheck;
  assign rsp.memory_error     = held.memory_error;
  assign rsp.crd_interrupt    = held.crd_interrupt;
  assign rsp.captured_timeout = held.captured_timeout;

endmodule
